>>> src/assert_macros.svh
// Assertion macros used by the framed command decoder RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/fcd_pkg.sv
// Types and character codes for the framed command decoder
`default_nettype none

package fcd_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [1:0]  kind_t;
  typedef logic [15:0] size_t;

  localparam byte_t CH_START = 8'h40;
  localparam byte_t CH_END   = 8'h3B;
  localparam byte_t CH_C     = 8'h43;
  localparam byte_t CH_E     = 8'h45;
  localparam byte_t CH_B     = 8'h42;
  localparam byte_t CH_A     = 8'h41;
  localparam byte_t CH_H     = 8'h48;
  localparam byte_t CH_S     = 8'h53;

  localparam size_t DIGIT_BASE = 16'd48;
  localparam size_t WEIGHT_100 = 16'd100;
  localparam size_t WEIGHT_10  = 16'd10;

  localparam kind_t KIND_MOTOR   = 2'd0;
  localparam kind_t KIND_BLOCK   = 2'd1;
  localparam kind_t KIND_HARVEST = 2'd2;
  localparam kind_t KIND_IGNORED = 2'd3;

endpackage

`default_nettype wire

>>> src/framed_command_decoder_unit.sv
// Framed command decoder: byte capture, frame store and frame decode
// A ';' word is held in the input register, then its result goes to the result register.
// Throughput: one input word per cycle while in_stall is low; other bytes give no result.
// A ';' word waits in the input register only while a result is stalled.
// Synchronous active-low reset clears capture state, position, frame
// store, harvest flag and both valid flags.
`default_nettype none

`include "assert_macros.svh"

module framed_command_decoder_unit #(
  parameter int FRAME_DEPTH = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire fcd_pkg::byte_t in_rx_byte,
  output logic               out_valid,
  input  wire logic          out_stall,
  output fcd_pkg::kind_t     out_frame_kind,
  output fcd_pkg::byte_t     out_motor_byte_a,
  output fcd_pkg::byte_t     out_motor_byte_b,
  output fcd_pkg::byte_t     out_motor_byte_c,
  output fcd_pkg::byte_t     out_motor_byte_d,
  output fcd_pkg::size_t     out_block_size,
  output logic               out_harvesting
);

  import fcd_pkg::*;

  localparam int POS_W = $clog2(FRAME_DEPTH + 1);
  localparam int IDX_W = $clog2(FRAME_DEPTH);

  // input register
  logic  s1_valid_r, s1_valid_nxt;
  byte_t s1_byte_r;

  // frame state
  logic             capturing_r, capturing_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  byte_t            store_r   [FRAME_DEPTH];
  byte_t            store_nxt [FRAME_DEPTH];
  logic             harvest_r, harvest_nxt;

  // result register
  logic  out_valid_r, out_valid_nxt;
  kind_t kind_r, kind_nxt;
  byte_t mot_a_r, mot_a_nxt, mot_b_r, mot_b_nxt;
  byte_t mot_c_r, mot_c_nxt, mot_d_r, mot_d_nxt;
  size_t size_r, size_nxt;
  logic  harv_out_r, harv_out_nxt;

  logic  s1_is_end, s1_is_start, s1_adv, out_free, in_take;
  logic  cap_now, wr_en;
  size_t d3, d4, d5, digit_sum;

  assign s1_is_end   = (s1_byte_r == CH_END);
  assign s1_is_start = (s1_byte_r == CH_START);
  assign out_free    = !out_valid_r || !out_stall;
  assign s1_adv      = s1_valid_r && (!s1_is_end || out_free);
  assign in_stall    = s1_valid_r && !s1_adv;
  assign in_take     = in_valid && !in_stall;

  assign s1_valid_nxt = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);

  assign cap_now = capturing_r || s1_is_start;
  assign wr_en   = s1_adv && cap_now && (pos_r < POS_W'(FRAME_DEPTH));

  always_comb begin
    for (int i = 0; i < FRAME_DEPTH; i++) begin
      store_nxt[i] = (wr_en && (pos_r[IDX_W-1:0] == IDX_W'(i))) ? s1_byte_r : store_r[i];
    end
    capturing_nxt = capturing_r;
    pos_nxt       = pos_r;
    if (s1_adv) begin
      if (s1_is_end) begin
        capturing_nxt = 1'b0;
        pos_nxt       = '0;
      end else begin
        capturing_nxt = cap_now;
        if (wr_en) begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
    end
  end

  assign d3 = size_t'(store_nxt[3]) - DIGIT_BASE;
  assign d4 = size_t'(store_nxt[4]) - DIGIT_BASE;
  assign d5 = size_t'(store_nxt[5]) - DIGIT_BASE;
  assign digit_sum = size_t'(d3 * WEIGHT_100) + size_t'(d4 * WEIGHT_10) + d5;

  always_comb begin
    kind_nxt    = KIND_IGNORED;
    mot_a_nxt   = '0;
    mot_b_nxt   = '0;
    mot_c_nxt   = '0;
    mot_d_nxt   = '0;
    size_nxt    = '0;
    harvest_nxt = harvest_r;
    if (store_nxt[1] == CH_C) begin
      kind_nxt  = KIND_MOTOR;
      mot_a_nxt = store_nxt[4];
      mot_b_nxt = store_nxt[5];
      mot_c_nxt = store_nxt[6];
      mot_d_nxt = store_nxt[7];
    end else if (store_nxt[1] == CH_E) begin
      if (store_nxt[2] == CH_B) begin
        kind_nxt = KIND_BLOCK;
        size_nxt = digit_sum;
      end
    end else if (store_nxt[1] == CH_A) begin
      if (store_nxt[3] == CH_H) begin
        kind_nxt = KIND_HARVEST;
        if (store_nxt[4] == CH_S) begin
          harvest_nxt = 1'b1;
        end else if (store_nxt[4] == CH_E) begin
          harvest_nxt = 1'b0;
        end
      end
    end
    harv_out_nxt = harvest_nxt;
  end

  assign out_valid_nxt = (s1_adv && s1_is_end) ? 1'b1 :
                         (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      capturing_r <= 1'b0;
      pos_r       <= '0;
      harvest_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < FRAME_DEPTH; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      capturing_r <= capturing_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < FRAME_DEPTH; i++) begin
        store_r[i] <= store_nxt[i];
      end
      if (s1_adv && s1_is_end) begin
        harvest_r <= harvest_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
    end
    if (s1_adv && s1_is_end) begin
      kind_r     <= kind_nxt;
      mot_a_r    <= mot_a_nxt;
      mot_b_r    <= mot_b_nxt;
      mot_c_r    <= mot_c_nxt;
      mot_d_r    <= mot_d_nxt;
      size_r     <= size_nxt;
      harv_out_r <= harv_out_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_kind   = kind_r;
  assign out_motor_byte_a = mot_a_r;
  assign out_motor_byte_b = mot_b_r;
  assign out_motor_byte_c = mot_c_r;
  assign out_motor_byte_d = mot_d_r;
  assign out_block_size   = size_r;
  assign out_harvesting   = harv_out_r;

  `ASSERT_IMP(a_pos_bound, 1'b1, pos_r <= POS_W'(FRAME_DEPTH))
  `ASSERT_NXT(a_end_clears, s1_adv && s1_is_end, (pos_r == '0) && !capturing_r && out_valid_r)
  `ASSERT_IMP(a_stall_cause, in_stall, s1_is_end && out_valid_r && out_stall)
  `ASSERT_IMP(a_motor_zero, out_valid_r && (kind_r != KIND_MOTOR), (mot_a_r | mot_b_r | mot_c_r | mot_d_r) == '0)

endmodule

`default_nettype wire

>>> dv/tb.sv
// Testbench for framed_command_decoder_unit: stimulus, frame decode scoreboard and checks
`timescale 1ns / 1ps

module tb;
  import fcd_pkg::*;

  localparam int FRAME_DEPTH = 8;
  localparam int RANDOM_WORDS = 400;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    kind_t  kind;
    byte_t  motor_a;
    byte_t  motor_b;
    byte_t  motor_c;
    byte_t  motor_d;
    size_t  block_size;
    logic   harvesting;
  } decode_t;

  class frame_scoreboard;
    bit          capture_on;
    int unsigned wr_pos;
    byte_t       frame_mem [FRAME_DEPTH];
    bit          harvest_on;
    decode_t     pending_decodes [$];
    int unsigned mismatches;

    function new();
      capture_on = 1'b0;
      wr_pos = 0;
      foreach (frame_mem[i]) frame_mem[i] = '0;
      harvest_on = 1'b0;
      mismatches = 0;
    endfunction

    function decode_t decode_frame();
      decode_t d;
      d = '0;
      d.kind = KIND_IGNORED;
      if (frame_mem[1] == CH_C) begin
        d.kind = KIND_MOTOR;
        d.motor_a = frame_mem[4];
        d.motor_b = frame_mem[5];
        d.motor_c = frame_mem[6];
        d.motor_d = frame_mem[7];
      end else if (frame_mem[1] == CH_E) begin
        if (frame_mem[2] == CH_B) begin
          d.kind = KIND_BLOCK;
          d.block_size = (size_t'(frame_mem[3]) - DIGIT_BASE) * WEIGHT_100
                       + (size_t'(frame_mem[4]) - DIGIT_BASE) * WEIGHT_10
                       + (size_t'(frame_mem[5]) - DIGIT_BASE);
        end
      end else if (frame_mem[1] == CH_A) begin
        if (frame_mem[3] == CH_H) begin
          d.kind = KIND_HARVEST;
          if (frame_mem[4] == CH_S) begin
            harvest_on = 1'b1;
          end else if (frame_mem[4] == CH_E) begin
            harvest_on = 1'b0;
          end
        end
      end
      d.harvesting = harvest_on;
      return d;
    endfunction

    function void note_rx_word(byte_t b);
      if (b == CH_START) begin
        capture_on = 1'b1;
      end
      if (capture_on && wr_pos < FRAME_DEPTH) begin
        frame_mem[wr_pos] = b;
        wr_pos++;
      end
      if (b == CH_END) begin
        capture_on = 1'b0;
        wr_pos = 0;
        pending_decodes.push_back(decode_frame());
      end
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_decode(decode_t got);
      decode_t exp_d;
      if (pending_decodes.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
        return;
      end
      exp_d = pending_decodes.pop_front();
      compare_field("frame_kind", exp_d.kind, got.kind);
      compare_field("motor_byte_a", exp_d.motor_a, got.motor_a);
      compare_field("motor_byte_b", exp_d.motor_b, got.motor_b);
      compare_field("motor_byte_c", exp_d.motor_c, got.motor_c);
      compare_field("motor_byte_d", exp_d.motor_d, got.motor_d);
      compare_field("block_size", exp_d.block_size, got.block_size);
      compare_field("harvesting", exp_d.harvesting, got.harvesting);
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  byte_t in_rx_byte = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  kind_t out_frame_kind;
  byte_t out_motor_byte_a;
  byte_t out_motor_byte_b;
  byte_t out_motor_byte_c;
  byte_t out_motor_byte_d;
  size_t out_block_size;
  logic  out_harvesting;

  frame_scoreboard sb = new();
  bit              quiet = 1'b0;
  int unsigned     words_sent = 0;
  int unsigned     stall_left = 0;
  int unsigned     cycle_count = 0;

  framed_command_decoder_unit #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_frame_kind(out_frame_kind),
    .out_motor_byte_a(out_motor_byte_a),
    .out_motor_byte_b(out_motor_byte_b),
    .out_motor_byte_c(out_motor_byte_c),
    .out_motor_byte_d(out_motor_byte_d),
    .out_block_size(out_block_size),
    .out_harvesting(out_harvesting)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic int unsigned draw_wait();
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  // result side: check accepted words, then stall the output for a random wait from draw_wait
  always @(posedge clk) begin
    decode_t got;
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.kind = out_frame_kind;
        got.motor_a = out_motor_byte_a;
        got.motor_b = out_motor_byte_b;
        got.motor_c = out_motor_byte_c;
        got.motor_d = out_motor_byte_d;
        got.block_size = out_block_size;
        got.harvesting = out_harvesting;
        sb.check_decode(got);
        stall_left = draw_wait();
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  task automatic send_word(input byte_t b);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_rx_word(b);
    words_sent++;
  endtask

  task automatic send_words(input byte_t words [$]);
    foreach (words[i]) send_word(words[i]);
  endtask

  task automatic drain_decodes();
    in_valid <= 1'b0;
    while (sb.pending_decodes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic byte_t body_byte();
    byte_t b;
    b = byte_t'($urandom_range(0, 255));
    if (b == CH_END) begin
      b = CH_START;
    end
    return b;
  endfunction

  function automatic byte_t digit_byte();
    if ($urandom_range(0, 4) == 0) begin
      return body_byte();
    end
    return byte_t'(DIGIT_BASE) + byte_t'($urandom_range(0, 9));
  endfunction

  task automatic send_random_frame();
    byte_t       words [$];
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      words = '{CH_START, CH_C, body_byte(), body_byte(),
                body_byte(), body_byte(), body_byte(), body_byte()};
      repeat ($urandom_range(0, 2)) words.push_back(body_byte());
      words.push_back(CH_END);
    end else if (pick < 38) begin
      words = '{CH_START, CH_E, CH_B, digit_byte(), digit_byte(), digit_byte(), CH_END};
    end else if (pick < 58) begin
      case ($urandom_range(0, 2))
        0: words = '{CH_START, CH_A, body_byte(), CH_H, CH_S, CH_END};
        1: words = '{CH_START, CH_A, body_byte(), CH_H, CH_E, CH_END};
        default: words = '{CH_START, CH_A, body_byte(), CH_H, body_byte(), CH_END};
      endcase
    end else if (pick < 70) begin
      case ($urandom_range(0, 2))
        0: words = '{CH_START, CH_E, body_byte(), body_byte(), body_byte(), CH_END};
        1: words = '{CH_START, CH_A, body_byte(), body_byte(), CH_S, CH_END};
        default: words = '{CH_START, body_byte(), body_byte(), body_byte(), CH_END};
      endcase
    end else if (pick < 80) begin
      words = '{CH_START};
      repeat ($urandom_range(0, 3)) words.push_back(body_byte());
      words.push_back(CH_END);
    end else if (pick < 92) begin
      repeat ($urandom_range(1, 5)) words.push_back(byte_t'($urandom_range(0, 255)));
    end else begin
      words = '{CH_END};
    end
    send_words(words);
  endtask

  initial begin
    bit drained;
    drained = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // end marker with nothing captured, then motor frame with a second start
    // marker inside it and an overflow that keeps the end marker out of the store
    send_words('{CH_END});
    send_words('{CH_START, CH_C, CH_START, 8'h11, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h22, CH_END});
    send_words('{CH_START, CH_E, CH_B, 8'h39, 8'h39, 8'h39, CH_END});
    send_words('{CH_START, CH_A, CH_H, CH_H, CH_S, CH_END});
    send_words('{CH_START, CH_A, CH_H, CH_H, CH_E, CH_END});
    drain_decodes();

    while (words_sent < RANDOM_WORDS + 30) begin
      if ($urandom_range(0, 11) == 0) begin
        quiet = ($urandom_range(0, 2) == 0);
      end
      if (!drained && words_sent >= 200) begin
        drain_decodes();
        drained = 1'b1;
      end
      send_random_frame();
    end
    in_valid <= 1'b0;

    while (sb.pending_decodes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/fcd_pkg.sv
src/framed_command_decoder_unit.sv
dv/tb.sv
